// File: hdl/llf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llf_pkg
// Shared types and constants of the log line framer.
// ---------------------------------------------------------------------------
package llf_pkg;

  localparam int LenW  = 21;
  localparam int OffW  = 48;
  localparam int GenW  = 16;
  localparam int TickW = 16;
  localparam int CfgW  = 21;

  localparam logic [LenW-1:0] MaxLine = 21'd1048576;

  localparam logic [7:0] NewlineByte = 8'h0A;
  localparam logic [7:0] ReturnByte  = 8'h0D;

  localparam logic [1:0] OpData    = 2'd0;
  localparam logic [1:0] OpTick    = 2'd1;
  localparam logic [1:0] OpEof     = 2'd2;
  localparam logic [1:0] OpRestart = 2'd3;

  localparam logic CfgMaxLine   = 1'b0;
  localparam logic CfgIdleTicks = 1'b1;

  localparam logic KindText = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam int QueueDepth = 4;

  // one queue entry: the results of one request; an optional held
  // return goes first, the main result is always the last one
  typedef struct packed {
    logic            has_cr;
    logic            kind;
    logic [7:0]      text_byte;
    logic [LenW-1:0] line_length;
    logic            truncated;
    logic [GenW-1:0] generation;
    logic [OffW-1:0] end_offset;
  } rec_t;

endpackage

// File: hdl/llf_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llf_front
// Accepts requests, tracks line state and builds one queue entry per request
// that causes results.
// ---------------------------------------------------------------------------
module llf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [1:0]                op,
  input  logic [7:0]                data_byte,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [llf_pkg::CfgW-1:0]  cfg_wdata,
  output logic                      push,
  output llf_pkg::rec_t             rec
);

  logic [llf_pkg::OffW-1:0]  off_r,   off_nxt;
  logic [llf_pkg::LenW-1:0]  lc_r,    lc_nxt;
  logic                      held_r,  held_nxt;
  logic                      skip_r,  skip_nxt;
  logic [llf_pkg::TickW-1:0] idle_r,  idle_nxt;
  logic [llf_pkg::GenW-1:0]  gen_r,   gen_nxt;
  logic [llf_pkg::LenW-1:0]  mx_r;
  logic [llf_pkg::TickW-1:0] ticks_r;

  logic [llf_pkg::OffW-1:0]  off_inc;
  logic [llf_pkg::LenW-1:0]  lc1;
  logic [llf_pkg::TickW-1:0] idle_inc;
  logic                      pending;
  logic                      is_nl;
  logic                      is_cr;
  logic                      take;

  assign off_inc  = off_r + {{(llf_pkg::OffW-1){1'b0}}, 1'b1};
  assign lc1      = lc_r + {{(llf_pkg::LenW-1){1'b0}}, held_r};
  assign idle_inc = (idle_r == '1) ? idle_r : idle_r + {{(llf_pkg::TickW-1){1'b0}}, 1'b1};
  assign pending  = (lc_r != '0) || held_r;
  assign is_nl    = (data_byte == llf_pkg::NewlineByte);
  assign is_cr    = (data_byte == llf_pkg::ReturnByte);

  always_comb begin
    off_nxt  = off_r;
    lc_nxt   = lc_r;
    held_nxt = held_r;
    skip_nxt = skip_r;
    idle_nxt = idle_r;
    gen_nxt  = gen_r;
    take     = 1'b0;
    rec.has_cr      = 1'b0;
    rec.kind        = llf_pkg::KindEnd;
    rec.text_byte   = data_byte;
    rec.line_length = lc_r;
    rec.truncated   = 1'b0;
    rec.generation  = gen_r;
    rec.end_offset  = off_r;
    if (accept) begin
      case (op)
        llf_pkg::OpData: begin
          idle_nxt = '0;
          off_nxt  = off_inc;
          if (skip_r) begin
            if (is_nl) begin
              skip_nxt = 1'b0;
            end
          end else if (held_r && is_nl) begin
            take            = 1'b1;
            rec.truncated   = (lc_r >= mx_r);
            rec.end_offset  = off_inc;
            lc_nxt          = '0;
            held_nxt        = 1'b0;
          end else begin
            held_nxt   = 1'b0;
            rec.has_cr = held_r;
            rec.line_length = lc1;
            if (is_nl) begin
              take           = 1'b1;
              rec.truncated  = (lc1 > mx_r);
              rec.end_offset = off_inc;
              lc_nxt         = '0;
            end else if (lc1 >= mx_r) begin
              take          = 1'b1;
              rec.truncated = 1'b1;
              lc_nxt        = '0;
              skip_nxt      = 1'b1;
            end else if (is_cr) begin
              // emit only the earlier return, hold the new one
              take          = held_r;
              rec.has_cr    = 1'b0;
              rec.kind      = llf_pkg::KindText;
              rec.text_byte = llf_pkg::ReturnByte;
              held_nxt      = 1'b1;
              lc_nxt        = lc1;
            end else begin
              take     = 1'b1;
              rec.kind = llf_pkg::KindText;
              lc_nxt   = lc1 + {{(llf_pkg::LenW-1){1'b0}}, 1'b1};
            end
          end
        end
        llf_pkg::OpTick: begin
          if ((ticks_r != '0) && pending && !skip_r) begin
            if (idle_inc >= ticks_r) begin
              take     = 1'b1;
              lc_nxt   = '0;
              held_nxt = 1'b0;
              idle_nxt = '0;
            end else begin
              idle_nxt = idle_inc;
            end
          end
        end
        llf_pkg::OpEof: begin
          take     = pending && !skip_r;
          gen_nxt  = gen_r + {{(llf_pkg::GenW-1){1'b0}}, 1'b1};
          off_nxt  = '0;
          lc_nxt   = '0;
          held_nxt = 1'b0;
          skip_nxt = 1'b0;
          idle_nxt = '0;
        end
        default: begin
          gen_nxt  = gen_r + {{(llf_pkg::GenW-1){1'b0}}, 1'b1};
          off_nxt  = '0;
          lc_nxt   = '0;
          held_nxt = 1'b0;
          skip_nxt = 1'b0;
          idle_nxt = '0;
        end
      endcase
    end
  end

  assign push = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      lc_r    <= '0;
      held_r  <= 1'b0;
      skip_r  <= 1'b0;
      idle_r  <= '0;
      gen_r   <= {{(llf_pkg::GenW-1){1'b0}}, 1'b1};
      mx_r    <= llf_pkg::MaxLine;
      ticks_r <= '0;
    end else begin
      off_r  <= off_nxt;
      lc_r   <= lc_nxt;
      held_r <= held_nxt;
      skip_r <= skip_nxt;
      idle_r <= idle_nxt;
      gen_r  <= gen_nxt;
      if (cfg_we) begin
        case (cfg_index)
          llf_pkg::CfgMaxLine: begin
            if ((cfg_wdata == '0) || (cfg_wdata > llf_pkg::MaxLine)) begin
              mx_r <= llf_pkg::MaxLine;
            end else begin
              mx_r <= cfg_wdata;
            end
          end
          llf_pkg::CfgIdleTicks: begin
            ticks_r <= cfg_wdata[llf_pkg::TickW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> (lc_r == '0) && !held_r)
    else $error("skip with pending line state");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r <= llf_pkg::MaxLine)
    else $error("line count beyond maximum");

  a_idle_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (idle_r != '0) |-> !skip_r)
    else $error("idle count running while skipping");

endmodule

// File: hdl/llf_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llf_queue
// Short entry queue between the front and back parts.
// ---------------------------------------------------------------------------
module llf_queue #(
  parameter int DEPTH = llf_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  llf_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          not_full,
  output logic          not_empty,
  output llf_pkg::rec_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  llf_pkg::rec_t     mem_r [DEPTH];
  logic [PtrW-1:0]   wr_r, wr_nxt;
  logic [PtrW-1:0]   rd_r, rd_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != CntW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PtrW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PtrW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

// File: hdl/llf_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llf_back
// Serializes queue entries into result items, a held return first.
// ---------------------------------------------------------------------------
module llf_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  llf_pkg::rec_t             head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [7:0]                out_text_byte,
  output logic [llf_pkg::LenW-1:0]  out_line_length,
  output logic                      out_truncated,
  output logic [llf_pkg::GenW-1:0]  out_generation,
  output logic [llf_pkg::OffW-1:0]  out_end_offset,
  output logic                      out_last
);

  logic phase_r;
  logic show_cr;
  logic is_end;

  assign show_cr = head.has_cr && !phase_r;
  assign is_end  = !show_cr && (head.kind == llf_pkg::KindEnd);

  assign out_valid       = head_valid;
  assign out_kind        = show_cr ? llf_pkg::KindText : head.kind;
  assign out_text_byte   = show_cr ? llf_pkg::ReturnByte : (is_end ? 8'h00 : head.text_byte);
  assign out_line_length = is_end ? head.line_length : '0;
  assign out_truncated   = is_end && head.truncated;
  assign out_generation  = head.generation;
  assign out_end_offset  = is_end ? head.end_offset : '0;
  assign out_last        = !show_cr;
  assign pop             = head_valid && out_ready && !show_cr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (head_valid && out_ready) begin
      phase_r <= show_cr;
    end
  end

endmodule

// File: hdl/log_line_framer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// log_line_framer_unit
// Splits a byte stream into lines with text results and end markers.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_op, in_data_byte
//   out      output     out_valid / out_ready  out_kind .. out_last
//   cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// One request per cycle is taken while the entry queue has room; the front
// updates line state in the accepting cycle and writes at most one entry.
// The back drains one result per cycle while out_ready is high; a request with
// two results occupies the output for both; the output port sets the sustained rate.
// A result shows on the output in the cycle after its request at the earliest.
// Synchronous reset returns line state, queue and configuration to their initial values.
// ---------------------------------------------------------------------------
module log_line_framer_unit #(
  parameter int QUEUE_DEPTH = llf_pkg::QueueDepth
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_op,
  input  logic [7:0]                in_data_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [7:0]                out_text_byte,
  output logic [llf_pkg::LenW-1:0]  out_line_length,
  output logic                      out_truncated,
  output logic [llf_pkg::GenW-1:0]  out_generation,
  output logic [llf_pkg::OffW-1:0]  out_end_offset,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [llf_pkg::CfgW-1:0]  cfg_wdata
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          q_not_empty;
  llf_pkg::rec_t push_rec;
  llf_pkg::rec_t head;

  assign accept = in_valid && in_ready;

  llf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_op),
    .data_byte (in_data_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .rec       (push_rec)
  );

  llf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .not_full  (in_ready),
    .not_empty (q_not_empty),
    .head      (head)
  );

  llf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_not_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_text_byte   (out_text_byte),
    .out_line_length (out_line_length),
    .out_truncated   (out_truncated),
    .out_generation  (out_generation),
    .out_end_offset  (out_end_offset),
    .out_last        (out_last)
  );

endmodule
